// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// A sequence property that holds outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`endif

// ===== rtl/adctpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adctpc_pkg
// Shared types and constants of the two-point ADC calibration block.
// ----------------------------------------------------------------------------
package adctpc_pkg;

  localparam int DEFAULT_NUM_CHANNELS = 4;
  localparam int DEFAULT_NUM_MODES    = 2;

  localparam int CODE_W = 16;
  localparam int QW     = 17;
  localparam int MAG_W  = 2 * QW;

  // Accept edge to the edge that samples the strobe.
  localparam int LATENCY = 22;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_CONVERT = 1'b1;

  typedef struct packed {
    logic [CODE_W-1:0] ideal_lo;
    logic [CODE_W-1:0] meas_lo;
    logic [CODE_W-1:0] ideal_hi;
    logic [CODE_W-1:0] meas_hi;
  } cal_entry_t;

  typedef struct packed {
    logic              valid;
    logic              pass;
    logic              neg;
    logic              ovf;
    logic [CODE_W-1:0] ideal_lo;
    logic [CODE_W-1:0] x;
  } side_t;

endpackage

// ===== rtl/adctpc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adctpc_div
// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees that the quotient fits in QW bits.
// ----------------------------------------------------------------------------
module adctpc_div #(
  parameter int QW = adctpc_pkg::QW
) (
  input  logic                clk,
  input  logic                rst_n,
  input  adctpc_pkg::side_t   side_in,
  input  logic [2*QW-1:0]     mag_in,
  input  logic [QW-1:0]       den_in,
  output adctpc_pkg::side_t   side_out,
  output logic [QW-1:0]       quo_out,
  output logic                rem_nz_out
);
  import adctpc_pkg::*;

  side_t          side_r [QW+1];
  logic [QW-1:0]  rem_r  [QW+1];
  logic [QW-1:0]  low_r  [QW+1];
  logic [QW-1:0]  quo_r  [QW+1];
  logic [QW-1:0]  den_r  [QW+1];

  always_comb begin
    side_r[0] = side_in;
    rem_r[0]  = mag_in[2*QW-1:QW];
    low_r[0]  = mag_in[QW-1:0];
    quo_r[0]  = '0;
    den_r[0]  = den_in;
  end

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [QW:0]   trial;
    logic          ge;
    logic [QW:0]   diff;
    logic [QW-1:0] rem_nxt;

    always_comb begin
      trial   = {rem_r[i], low_r[i][QW-1]};
      ge      = trial >= {1'b0, den_r[i]};
      diff    = trial - {1'b0, den_r[i]};
      rem_nxt = ge ? diff[QW-1:0] : trial[QW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[i+1] <= '0;
      end else begin
        side_r[i+1] <= side_r[i];
      end
      rem_r[i+1] <= rem_nxt;
      low_r[i+1] <= {low_r[i][QW-2:0], 1'b0};
      quo_r[i+1] <= {quo_r[i][QW-2:0], ge};
      den_r[i+1] <= den_r[i];
    end
  end

  assign side_out   = side_r[QW];
  assign quo_out    = quo_r[QW];
  assign rem_nz_out = |rem_r[QW];

endmodule

// ===== rtl/adc_two_point_calibration.sv =====
`timescale 1ns / 1ps
// A convert transfer passes stages 1 to 4, the divider and the output register.
// Throughput: one item per cycle; busy stays low, so start may be held high.
// Most of the latency is the 17-stage divider pipeline, one quotient bit a stage.
// Load transfers write the table at the accepting edge and give no result.
// Synchronous reset clears the table and all pipeline valid bits.
// ----------------------------------------------------------------------------
// adc_two_point_calibration
// Two-point gain and offset correction of ADC samples with a per mode and
// channel calibration table, fully pipelined.
// ----------------------------------------------------------------------------
module adc_two_point_calibration #(
  parameter int NUM_CHANNELS = adctpc_pkg::DEFAULT_NUM_CHANNELS,
  parameter int NUM_MODES    = adctpc_pkg::DEFAULT_NUM_MODES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [15:0] in_raw_code,
  input  logic [2:0]  in_channel,
  input  logic [1:0]  in_cal_mode,
  input  logic [15:0] in_ideal_low,
  input  logic [15:0] in_measured_low,
  input  logic [15:0] in_ideal_high,
  input  logic [15:0] in_measured_high,
  output logic        out_valid,
  output logic [15:0] out_calibrated_code,
  output logic        out_applied
);
  import adctpc_pkg::*;

  localparam int DEPTH = NUM_MODES * NUM_CHANNELS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cal_entry_t table_r [DEPTH];

  logic          accept;
  logic [1:0]    mode_sel;
  logic [4:0]    idx_full;
  logic [AW-1:0] tbl_idx;
  logic          ch_ok;
  cal_entry_t    rd_entry;
  logic [15:0]   x_in;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign x_in   = in_raw_code ^ 16'h8000;

  always_comb begin
    mode_sel = (in_cal_mode > 2'd1) ? 2'd1 : in_cal_mode;
    if ({30'd0, mode_sel} >= NUM_MODES) begin
      mode_sel = 2'(NUM_MODES - 1);
    end
    ch_ok    = {1'b0, in_channel} < 4'(NUM_CHANNELS);
    idx_full = 5'(mode_sel) * 5'(NUM_CHANNELS) + 5'(in_channel);
    tbl_idx  = idx_full[AW-1:0];
    rd_entry = ch_ok ? table_r[tbl_idx] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        table_r[i] <= '0;
      end
    end else if (accept && in_req_type == REQ_LOAD && ch_ok) begin
      table_r[tbl_idx] <= '{ideal_lo: in_ideal_low, meas_lo: in_measured_low,
                            ideal_hi: in_ideal_high, meas_hi: in_measured_high};
    end
  end

  // Stage 1: table entry and sample.
  logic        s1_valid_r;
  logic        s1_chok_r;
  cal_entry_t  s1_entry_r;
  logic [15:0] s1_x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept && in_req_type == REQ_CONVERT;
    end
    s1_chok_r  <= ch_ok;
    s1_entry_r <= rd_entry;
    s1_x_r     <= x_in;
  end

  // Stage 2: differences with the sign of the span folded into the gain.
  logic signed [16:0] d_ideal;
  logic signed [16:0] d_meas;
  logic signed [16:0] d_x;
  logic signed [16:0] s2_dideal_nxt;
  logic [15:0]        s2_dabs_nxt;

  always_comb begin
    d_ideal = $signed({1'b0, s1_entry_r.ideal_hi}) - $signed({1'b0, s1_entry_r.ideal_lo});
    d_meas  = $signed({1'b0, s1_entry_r.meas_hi}) - $signed({1'b0, s1_entry_r.meas_lo});
    d_x     = $signed({1'b0, s1_x_r}) - $signed({1'b0, s1_entry_r.meas_lo});
    s2_dideal_nxt = d_meas[16] ? -d_ideal : d_ideal;
    s2_dabs_nxt   = d_meas[16] ? 16'(-d_meas) : d_meas[15:0];
  end

  logic               s2_valid_r;
  logic               s2_pass_r;
  logic signed [16:0] s2_dideal_r;
  logic signed [16:0] s2_dx_r;
  logic [15:0]        s2_dabs_r;
  logic [15:0]        s2_il_r;
  logic [15:0]        s2_x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_pass_r   <= !s1_chok_r || d_meas == 17'sd0;
    s2_dideal_r <= s2_dideal_nxt;
    s2_dx_r     <= d_x;
    s2_dabs_r   <= s2_dabs_nxt;
    s2_il_r     <= s1_entry_r.ideal_lo;
    s2_x_r      <= s1_x_r;
  end

  // Stage 3: product.
  logic               s3_valid_r;
  logic               s3_pass_r;
  logic signed [33:0] s3_num_r;
  logic [15:0]        s3_dabs_r;
  logic [15:0]        s3_il_r;
  logic [15:0]        s3_x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_pass_r <= s2_pass_r;
    s3_num_r  <= s2_dideal_r * s2_dx_r;
    s3_dabs_r <= s2_dabs_r;
    s3_il_r   <= s2_il_r;
    s3_x_r    <= s2_x_r;
  end

  // Stage 4: rounding numerator, magnitude and range check.
  logic signed [35:0] n_val;
  logic [35:0]        n_abs;
  logic [MAG_W-1:0]   n_mag;
  logic [QW-1:0]      d_val;
  logic               n_ovf;

  always_comb begin
    n_val = $signed({s3_num_r, 1'b0}) + $signed({20'd0, s3_dabs_r});
    n_abs = n_val[35] ? 36'(-n_val) : n_val;
    n_mag = n_abs[MAG_W-1:0];
    d_val = {s3_dabs_r, 1'b0};
    n_ovf = n_mag >= {d_val, {QW{1'b0}}};
  end

  side_t            s4_side_r;
  logic [MAG_W-1:0] s4_mag_r;
  logic [QW-1:0]    s4_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_side_r.valid <= 1'b0;
    end else begin
      s4_side_r.valid <= s3_valid_r;
    end
    s4_side_r.pass     <= s3_pass_r;
    s4_side_r.neg      <= n_val[35];
    s4_side_r.ovf      <= n_ovf;
    s4_side_r.ideal_lo <= s3_il_r;
    s4_side_r.x        <= s3_x_r;
    s4_mag_r           <= n_mag;
    s4_den_r           <= d_val;
  end

  side_t         dv_side;
  logic [QW-1:0] dv_quo;
  logic          dv_rem_nz;

  adctpc_div #(.QW(QW)) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .side_in    (s4_side_r),
    .mag_in     (s4_mag_r),
    .den_in     (s4_den_r),
    .side_out   (dv_side),
    .quo_out    (dv_quo),
    .rem_nz_out (dv_rem_nz)
  );

  // Final stage: pass-through, floor for negative quotients, offset and saturation.
  logic signed [18:0] q_s;
  logic signed [18:0] r_s;
  logic [15:0]        code_nxt;
  logic               applied_nxt;

  always_comb begin
    q_s = dv_side.neg ? -($signed({2'b0, dv_quo}) + $signed({18'd0, dv_rem_nz}))
                      : $signed({2'b0, dv_quo});
    r_s = $signed({3'b0, dv_side.ideal_lo}) + q_s;
    applied_nxt = !dv_side.pass;
    if (dv_side.pass) begin
      code_nxt = dv_side.x;
    end else if (dv_side.ovf) begin
      code_nxt = dv_side.neg ? 16'h0000 : 16'hFFFF;
    end else if (r_s < 0) begin
      code_nxt = 16'h0000;
    end else if (r_s > 19'sd65535) begin
      code_nxt = 16'hFFFF;
    end else begin
      code_nxt = r_s[15:0];
    end
  end

  logic        out_valid_r;
  logic [15:0] out_code_r;
  logic        out_applied_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      out_applied_r <= 1'b0;
    end else begin
      out_valid_r   <= dv_side.valid;
      out_applied_r <= dv_side.valid && applied_nxt;
    end
    out_code_r <= code_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_calibrated_code = out_code_r;
  assign out_applied         = out_applied_r;

endmodule

// ===== rtl/adctpc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adctpc_checker
// Port-level checks of the calibration block's transfer timing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adctpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_req_type,
  input logic        out_valid,
  input logic        out_applied
);
  import adctpc_pkg::*;

  `ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)
  `ASSERT_ALWAYS(a_applied_with_strobe, clk, rst_n, !out_applied || out_valid)
  `ASSERT_PROP(a_convert_gives_result, clk, rst_n, (start && !busy && in_req_type == REQ_CONVERT) |-> ##LATENCY out_valid)
  `ASSERT_PROP(a_load_gives_none, clk, rst_n, (start && !busy && in_req_type == REQ_LOAD) |-> ##LATENCY !out_valid)
  `ASSERT_PROP(a_no_spurious, clk, rst_n, $past(!start, LATENCY) |-> !out_valid)

endmodule

bind adc_two_point_calibration adctpc_checker u_adctpc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_req_type (in_req_type),
  .out_valid   (out_valid),
  .out_applied (out_applied)
);
